FILE: hdl/wcsp_pkg.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser package
// Shared types and constants for the byte-serial WAV header parser.
// ----------------------------------------------------------------------------
package wcsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] TAG_LIST = 32'h4C495354;
    localparam logic [31:0] TAG_JUNK = 32'h4A554E4B;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [32:0] FMT_MIN  = 33'd16;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ERR_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [2:0] ERR_SHORT_FMT = 3'd4;

    localparam logic [32:0] CONSUMED_RESET = 33'd4;

    typedef enum logic [2:0] {
        TG_RIFF,
        TG_WAVE,
        TG_FMT,
        TG_DATA,
        TG_SKIP,
        TG_OTHER
    } t_tag;

    typedef enum logic [1:0] {
        CT_FMT,
        CT_DATA,
        CT_SKIP
    } t_chunk;

    typedef struct packed {
        logic [7:0] data;
        logic       file_start;
        t_tag       tag;
    } t_q_entry;

endpackage

FILE: hdl/wcsp_front.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser front end
// Accepts bytes and classifies the four-byte window that ends at each byte.
// ----------------------------------------------------------------------------
module wcsp_front
    import wcsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_q_entry   o_entry
);

    logic [23:0] r_hist;
    logic [23:0] n_hist;
    logic [31:0] window;
    t_tag        tag;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign window     = {r_hist, i_in_byte};
    assign n_hist     = window[23:0];

    always_comb begin
        priority if (window == TAG_RIFF) begin
            tag = TG_RIFF;
        end else if (window == TAG_WAVE) begin
            tag = TG_WAVE;
        end else if (window == TAG_FMT) begin
            tag = TG_FMT;
        end else if (window == TAG_DATA) begin
            tag = TG_DATA;
        end else if (window == TAG_LIST || window == TAG_JUNK) begin
            tag = TG_SKIP;
        end else begin
            tag = TG_OTHER;
        end
    end

    assign o_entry = '{data: i_in_byte, file_start: i_file_start, tag: tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (o_push) begin
            r_hist <= n_hist;
        end
    end

endmodule

FILE: hdl/wcsp_queue.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser queue
// Short first-in first-out queue between the front end and the parser core.
// ----------------------------------------------------------------------------
module wcsp_queue
    import wcsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_q_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_q_entry      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hdl/wcsp_back.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser core
// Runs the RIFF/WAVE parse one queued byte per cycle, while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module wcsp_back
    import wcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_q_entry    i_q_entry,
    output logic        o_q_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_bits_per_sample,
    output logic [31:0] o_data_bytes,
    output logic [2:0]  o_error_code
);

    typedef enum logic [9:0] {
        PH_RIFF  = 10'b00_0000_0001,
        PH_RSIZE = 10'b00_0000_0010,
        PH_WAVE  = 10'b00_0000_0100,
        PH_TAG   = 10'b00_0000_1000,
        PH_SIZE  = 10'b00_0001_0000,
        PH_FMT   = 10'b00_0010_0000,
        PH_SKIP  = 10'b00_0100_0000,
        PH_DATA  = 10'b00_1000_0000,
        PH_DONE  = 10'b01_0000_0000,
        PH_ERR   = 10'b10_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [31:0] r_cnt, n_cnt, cur_cnt;
    logic [31:0] r_riff, n_riff, cur_riff;
    logic [32:0] r_consumed, n_consumed, cur_consumed;
    logic [31:0] r_chunk_size, n_chunk_size, cur_chunk_size;
    t_chunk      r_chunk_type, n_chunk_type, cur_chunk_type;
    logic [15:0] r_channels, n_channels, cur_channels;
    logic [31:0] r_rate, n_rate, cur_rate;
    logic [15:0] r_bits, n_bits, cur_bits;
    logic [31:0] r_data_size, n_data_size, cur_data_size;
    logic [2:0]  r_error, n_error, cur_error;

    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_pay, n_pay;
    logic        r_last, n_last;

    logic        fs;
    logic [7:0]  b;
    logic [32:0] cnt_inc;
    logic [33:0] fin_sum;
    logic [32:0] fin_consumed;
    logic        fin_done;
    logic        wave_done;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign fs      = i_q_entry.file_start;
    assign b       = i_q_entry.data;

    always_comb begin
        cur_phase      = fs ? PH_RIFF : r_phase;
        cur_cnt        = fs ? '0 : r_cnt;
        cur_riff       = fs ? '0 : r_riff;
        cur_consumed   = fs ? CONSUMED_RESET : r_consumed;
        cur_chunk_size = fs ? '0 : r_chunk_size;
        cur_chunk_type = fs ? CT_FMT : r_chunk_type;
        cur_channels   = fs ? '0 : r_channels;
        cur_rate       = fs ? '0 : r_rate;
        cur_bits       = fs ? '0 : r_bits;
        cur_data_size  = fs ? '0 : r_data_size;
        cur_error      = fs ? ERR_NONE : r_error;
    end

    assign cnt_inc      = {1'b0, cur_cnt} + 33'd1;
    assign fin_sum      = {1'b0, cur_consumed} + 34'd8 + {2'b00, n_chunk_size};
    assign fin_consumed = fin_sum[33] ? '1 : fin_sum[32:0];
    assign fin_done     = (fin_consumed >= {1'b0, cur_riff});
    assign wave_done    = (cur_consumed >= {1'b0, cur_riff});

    always_comb begin
        n_phase      = cur_phase;
        n_cnt        = cur_cnt;
        n_riff       = cur_riff;
        n_consumed   = cur_consumed;
        n_chunk_type = cur_chunk_type;
        n_channels   = cur_channels;
        n_rate       = cur_rate;
        n_bits       = cur_bits;
        n_data_size  = cur_data_size;
        n_error      = cur_error;
        n_kind       = KIND_HEADER;
        n_pay        = '0;
        n_last       = 1'b0;
        n_chunk_size = cur_chunk_size;
        if (cur_phase == PH_SIZE) begin
            n_chunk_size[cur_cnt[1:0]*8 +: 8] = b;
        end else if (cur_phase == PH_TAG && cur_cnt[1:0] == 2'd3) begin
            n_chunk_size = '0;
        end

        unique case (cur_phase)
            PH_RIFF, PH_WAVE, PH_TAG: begin
                if (cur_cnt[1:0] != 2'd3) begin
                    n_cnt = cnt_inc[31:0];
                end else begin
                    n_cnt = '0;
                    if (cur_phase == PH_RIFF) begin
                        if (i_q_entry.tag != TG_RIFF) begin
                            n_error = ERR_BAD_RIFF;
                            n_phase = PH_ERR;
                            n_kind  = KIND_ERROR;
                        end else begin
                            n_phase = PH_RSIZE;
                        end
                    end else if (cur_phase == PH_WAVE) begin
                        if (i_q_entry.tag != TG_WAVE) begin
                            n_error = ERR_BAD_WAVE;
                            n_phase = PH_ERR;
                            n_kind  = KIND_ERROR;
                        end else begin
                            n_phase = wave_done ? PH_DONE : PH_TAG;
                        end
                    end else begin
                        unique case (i_q_entry.tag)
                            TG_FMT: begin
                                n_chunk_type = CT_FMT;
                                n_phase      = PH_SIZE;
                            end
                            TG_DATA: begin
                                n_chunk_type = CT_DATA;
                                n_phase      = PH_SIZE;
                            end
                            TG_SKIP: begin
                                n_chunk_type = CT_SKIP;
                                n_phase      = PH_SIZE;
                            end
                            default: begin
                                n_error = ERR_UNKNOWN;
                                n_phase = PH_ERR;
                                n_kind  = KIND_ERROR;
                            end
                        endcase
                    end
                end
            end
            PH_RSIZE: begin
                n_riff[cur_cnt[1:0]*8 +: 8] = b;
                if (cur_cnt[1:0] != 2'd3) begin
                    n_cnt = cnt_inc[31:0];
                end else begin
                    n_cnt   = '0;
                    n_phase = PH_WAVE;
                end
            end
            PH_SIZE: begin
                if (cur_cnt[1:0] != 2'd3) begin
                    n_cnt = cnt_inc[31:0];
                end else begin
                    n_cnt = '0;
                    if (cur_chunk_type == CT_FMT) begin
                        if ({1'b0, n_chunk_size} < FMT_MIN) begin
                            n_error = ERR_SHORT_FMT;
                            n_phase = PH_ERR;
                            n_kind  = KIND_ERROR;
                        end else begin
                            n_phase = PH_FMT;
                        end
                    end else begin
                        if (cur_chunk_type == CT_DATA) begin
                            n_data_size = n_chunk_size;
                        end
                        if (n_chunk_size == '0) begin
                            n_consumed = fin_consumed;
                            n_phase    = fin_done ? PH_DONE : PH_TAG;
                        end else begin
                            n_phase = (cur_chunk_type == CT_DATA) ? PH_DATA : PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT: begin
                if (cur_cnt[3:1] == 3'd1) begin
                    n_channels[cur_cnt[0]*8 +: 8] = b;
                end else if (cur_cnt[3:2] == 2'd1) begin
                    n_rate[cur_cnt[1:0]*8 +: 8] = b;
                end else if (cur_cnt[3:1] == 3'd7) begin
                    n_bits[cur_cnt[0]*8 +: 8] = b;
                end
                n_cnt = cnt_inc[31:0];
                if (cnt_inc >= FMT_MIN) begin
                    if ({1'b0, cur_chunk_size} <= FMT_MIN) begin
                        n_cnt      = '0;
                        n_consumed = fin_consumed;
                        n_phase    = fin_done ? PH_DONE : PH_TAG;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP, PH_DATA: begin
                if (cur_phase == PH_DATA) begin
                    n_kind = KIND_PAYLOAD;
                    n_pay  = b;
                end
                n_cnt = cnt_inc[31:0];
                if (cnt_inc >= {1'b0, cur_chunk_size}) begin
                    n_last     = (cur_phase == PH_DATA);
                    n_cnt      = '0;
                    n_consumed = fin_consumed;
                    n_phase    = fin_done ? PH_DONE : PH_TAG;
                end
            end
            default: begin
                n_kind = KIND_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RIFF;
            r_cnt        <= '0;
            r_riff       <= '0;
            r_consumed   <= CONSUMED_RESET;
            r_chunk_size <= '0;
            r_chunk_type <= CT_FMT;
            r_channels   <= '0;
            r_rate       <= '0;
            r_bits       <= '0;
            r_data_size  <= '0;
            r_error      <= ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase      <= n_phase;
                r_cnt        <= n_cnt;
                r_riff       <= n_riff;
                r_consumed   <= n_consumed;
                r_chunk_size <= n_chunk_size;
                r_chunk_type <= n_chunk_type;
                r_channels   <= n_channels;
                r_rate       <= n_rate;
                r_bits       <= n_bits;
                r_data_size  <= n_data_size;
                r_error      <= n_error;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind <= n_kind;
            r_pay  <= n_pay;
            r_last <= n_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_payload_byte    = r_pay;
    assign o_payload_last    = r_last;
    assign o_channel_count   = r_channels;
    assign o_sample_rate     = r_rate;
    assign o_bits_per_sample = r_bits;
    assign o_data_bytes      = r_data_size;
    assign o_error_code      = r_error;

endmodule

FILE: hdl/wav_chunk_stream_parser.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser
// Byte-serial RIFF/WAVE header parser with format capture and data pass-through.
// ----------------------------------------------------------------------------
// One file byte is taken per transaction and exactly one result transaction
// comes out for it, at a sustained rate of one byte per clock while the
// output is not stalled. The front end classifies the tag window of each
// accepted byte into a queue of QUEUE_DEPTH entries, and the parser core
// then pops it and updates its state and the output register together.
// While the output is stalled the queue keeps accepting bytes until it fills.
module wav_chunk_stream_parser
    import wcsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_bits_per_sample,
    output logic [31:0] o_data_bytes,
    output logic [2:0]  o_error_code
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    t_q_entry q_in;
    t_q_entry q_out;

    wcsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    wcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    wcsp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_entry         (q_out),
        .o_q_pop           (q_pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_payload_last    (o_payload_last),
        .o_channel_count   (o_channel_count),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_data_bytes      (o_data_bytes),
        .o_error_code      (o_error_code)
    );

endmodule

FILE: hdl/wcsp_checker.sv
// ----------------------------------------------------------------------------
// WAV chunk stream parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wcsp_checker
    import wcsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic        o_payload_last,
    input logic [2:0]  o_error_code
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind))
        else $error("Stalled result transaction changed.");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_last |-> o_kind == KIND_PAYLOAD)
        else $error("Last flag on a non-payload transaction.");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_PAYLOAD |-> o_payload_byte == 8'd0)
        else $error("Payload byte set on a non-payload transaction.");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERROR |-> o_error_code != ERR_NONE)
        else $error("Error stop without an error code.");

    a_no_error_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_HEADER || o_kind == KIND_PAYLOAD)
            |-> o_error_code == ERR_NONE)
        else $error("Parsing continued after an error.");

endmodule

bind wav_chunk_stream_parser wcsp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_payload_last (o_payload_last),
    .o_error_code   (o_error_code)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV chunk stream parser testbench
// Feeds byte streams of WAV files through the parser and compares each result
// transaction field by field against a byte-level model of the parse. A short
// table of hand-picked bytes covers restarts, magic errors and ignored bytes, and
// random files follow: mostly well-formed headers with fmt, data, LIST, JUNK
// and unknown chunks, with damaged tags, short format chunks, odd RIFF sizes,
// trailing noise and restarts in the middle of a file.
// ----------------------------------------------------------------------------
module tb_top;
    import wcsp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1250;

    typedef enum logic [3:0] {
        P_RIFF, P_RSIZE, P_WAVE, P_TAG, P_SIZE, P_FMT, P_SKIP, P_DATA, P_DONE, P_ERR
    } t_parse_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic        last;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] data_size;
        logic [2:0]  err;
    } t_parse_result;

    typedef struct packed {
        logic [7:0] value;
        logic       start;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] err;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_payload_last;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [15:0] o_bits_per_sample;
    logic [31:0] o_data_bytes;
    logic [2:0]  o_error_code;

    t_parse_result expected_results[$];
    t_stim_row     directed_rows[$];
    logic [7:0]    file_img[$];

    int   fail_count = 0;
    int   cycle_count = 0;
    int   random_sent = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;

    t_parse_phase ph;
    logic [31:0]  fld_cnt;
    logic [31:0]  tag_win;
    logic [31:0]  riff_len;
    logic [32:0]  used_bytes;
    logic [31:0]  chk_len;
    t_chunk       chk_kind;
    logic [15:0]  cur_channels;
    logic [31:0]  cur_rate;
    logic [15:0]  cur_bits;
    logic [31:0]  cur_data_size;
    logic [2:0]   cur_err;

    wav_chunk_stream_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .i_file_start      (i_file_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_payload_last    (o_payload_last),
        .o_channel_count   (o_channel_count),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_data_bytes      (o_data_bytes),
        .o_error_code      (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function void clear_parse();
        ph            = P_RIFF;
        fld_cnt       = '0;
        tag_win       = '0;
        riff_len      = '0;
        used_bytes    = CONSUMED_RESET;
        chk_len       = '0;
        chk_kind      = CT_FMT;
        cur_channels  = '0;
        cur_rate      = '0;
        cur_bits      = '0;
        cur_data_size = '0;
        cur_err       = ERR_NONE;
    endfunction

    function void check_end();
        fld_cnt = '0;
        ph = (used_bytes >= {1'b0, riff_len}) ? P_DONE : P_TAG;
    endfunction

    function void close_chunk();
        logic [33:0] sum;
        sum = {1'b0, used_bytes} + 34'd8 + {2'b00, chk_len};
        used_bytes = sum[33] ? '1 : sum[32:0];
        check_end();
    endfunction

    function logic [1:0] stop_parse(input logic [2:0] code);
        cur_err = code;
        ph = P_ERR;
        return KIND_ERROR;
    endfunction

    function t_parse_result parse_byte(input logic [7:0] b, input logic start);
        t_parse_result r;
        logic [31:0]   n;
        r = '0;
        r.kind = KIND_HEADER;
        if (start)
            clear_parse();
        case (ph)
            P_RIFF, P_WAVE, P_TAG: begin
                tag_win = {tag_win[23:0], b};
                fld_cnt++;
                if (fld_cnt >= 4) begin
                    fld_cnt = '0;
                    if (ph == P_RIFF) begin
                        if (tag_win != TAG_RIFF) r.kind = stop_parse(ERR_BAD_RIFF);
                        else ph = P_RSIZE;
                    end else if (ph == P_WAVE) begin
                        if (tag_win != TAG_WAVE) r.kind = stop_parse(ERR_BAD_WAVE);
                        else check_end();
                    end else if (tag_win == TAG_FMT) begin
                        chk_kind = CT_FMT;
                        chk_len = '0;
                        ph = P_SIZE;
                    end else if (tag_win == TAG_DATA) begin
                        chk_kind = CT_DATA;
                        chk_len = '0;
                        ph = P_SIZE;
                    end else if (tag_win == TAG_LIST || tag_win == TAG_JUNK) begin
                        chk_kind = CT_SKIP;
                        chk_len = '0;
                        ph = P_SIZE;
                    end else begin
                        r.kind = stop_parse(ERR_UNKNOWN);
                    end
                end
            end
            P_RSIZE: begin
                riff_len[fld_cnt[1:0]*8 +: 8] = b;
                fld_cnt++;
                if (fld_cnt >= 4) begin
                    fld_cnt = '0;
                    ph = P_WAVE;
                end
            end
            P_SIZE: begin
                chk_len[fld_cnt[1:0]*8 +: 8] = b;
                fld_cnt++;
                if (fld_cnt >= 4) begin
                    fld_cnt = '0;
                    if (chk_kind == CT_FMT) begin
                        if ({1'b0, chk_len} < FMT_MIN) r.kind = stop_parse(ERR_SHORT_FMT);
                        else ph = P_FMT;
                    end else if (chk_kind == CT_DATA) begin
                        cur_data_size = chk_len;
                        if (chk_len == 0) close_chunk();
                        else ph = P_DATA;
                    end else begin
                        if (chk_len == 0) close_chunk();
                        else ph = P_SKIP;
                    end
                end
            end
            P_FMT: begin
                n = fld_cnt;
                if (n == 2 || n == 3) cur_channels[n[0]*8 +: 8] = b;
                else if (n >= 4 && n <= 7) cur_rate[n[1:0]*8 +: 8] = b;
                else if (n == 14 || n == 15) cur_bits[n[0]*8 +: 8] = b;
                fld_cnt++;
                if (fld_cnt >= 16) begin
                    if (chk_len <= 16) close_chunk();
                    else ph = P_SKIP;
                end
            end
            P_SKIP: begin
                fld_cnt++;
                if (fld_cnt >= chk_len)
                    close_chunk();
            end
            P_DATA: begin
                r.kind = KIND_PAYLOAD;
                r.payload = b;
                fld_cnt++;
                if (fld_cnt >= chk_len) begin
                    r.last = 1'b1;
                    close_chunk();
                end
            end
            default: begin
                r.kind = KIND_IGNORED;
            end
        endcase
        r.channels  = cur_channels;
        r.rate      = cur_rate;
        r.bits      = cur_bits;
        r.data_size = cur_data_size;
        r.err       = cur_err;
        return r;
    endfunction

    function void add_row(input logic [7:0] value, input logic start, input logic typed,
                          input logic [1:0] kind, input logic [2:0] err);
        directed_rows.push_back({value, start, typed, kind, err});
    endfunction

    function void put_be32(input logic [31:0] v);
        for (int k = 3; k >= 0; k--)
            file_img.push_back(v[k*8 +: 8]);
    endfunction

    function void put_le32(input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            file_img.push_back(v[k*8 +: 8]);
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic start);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_file_start <= start;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic start);
        offer_byte(b, start);
        expected_results.push_back(parse_byte(b, start));
        random_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_wav_file();
        int          n_chunks;
        int          pick;
        int          body_len;
        logic [31:0] len_field;
        logic [31:0] riff_field;
        logic [31:0] tag;
        logic [31:0] used;
        logic        restart;
        file_img.delete();
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 8))
                file_img.push_back(8'($urandom));
            restart = 1'($urandom_range(1));
        end else begin
            tag = TAG_RIFF;
            if ($urandom_range(99) < 4)
                tag ^= 32'd1 << $urandom_range(31);
            put_be32(tag);
            put_le32(32'd0);
            tag = TAG_WAVE;
            if ($urandom_range(99) < 4)
                tag ^= 32'd1 << $urandom_range(31);
            put_be32(tag);
            used = 32'd4;
            n_chunks = $urandom_range(1, 4);
            for (int c = 0; c < n_chunks; c++) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    tag = TAG_FMT;
                    body_len = ($urandom_range(99) < 10) ? $urandom_range(0, 15)
                                                         : $urandom_range(16, 22);
                    len_field = body_len;
                end else if (pick < 65) begin
                    tag = TAG_DATA;
                    body_len = $urandom_range(0, 16);
                    len_field = ($urandom_range(99) < 6) ? $urandom : body_len;
                end else if (pick < 90) begin
                    tag = $urandom_range(1) ? TAG_LIST : TAG_JUNK;
                    body_len = $urandom_range(0, 6);
                    len_field = body_len;
                end else begin
                    tag = $urandom;
                    body_len = $urandom_range(0, 4);
                    len_field = body_len;
                end
                put_be32(tag);
                put_le32(len_field);
                repeat (body_len)
                    file_img.push_back(8'($urandom));
                used += 8 + body_len;
            end
            pick = $urandom_range(99);
            if (pick < 70) riff_field = used;
            else if (pick < 80) riff_field = $urandom_range(0, used);
            else if (pick < 90) riff_field = used + $urandom_range(1, 40);
            else riff_field = $urandom;
            for (int k = 0; k < 4; k++)
                file_img[4 + k] = riff_field[k*8 +: 8];
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 6))
                    file_img.push_back(8'($urandom));
            restart = ($urandom_range(99) < 95);
        end
        foreach (file_img[k])
            feed_byte(file_img[k], restart && k == 0);
    endtask

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_parse_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result transaction with none expected, kind %0h",
                         $time, o_kind);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("payload_byte", want.payload, o_payload_byte);
                check_field("payload_last", want.last, o_payload_last);
                check_field("channel_count", want.channels, o_channel_count);
                check_field("sample_rate", want.rate, o_sample_rate);
                check_field("bits_per_sample", want.bits, o_bits_per_sample);
                check_field("data_bytes", want.data_size, o_data_bytes);
                check_field("error_code", want.err, o_error_code);
            end
        end
        i_out_stall <= hold_on || (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
    end

    initial begin
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_parse_result r;
        clear_parse();

        add_row(TAG_RIFF[31:24], 1'b0, 1'b1, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[23:16], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'hFF,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b1, KIND_ERROR,   ERR_BAD_RIFF);
        add_row(8'hFF,           1'b0, 1'b1, KIND_IGNORED, ERR_BAD_RIFF);
        add_row(TAG_RIFF[31:24], 1'b1, 1'b1, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[23:16], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[15:8],  1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[7:0],   1'b0, 1'b1, KIND_HEADER,  ERR_NONE);
        add_row(8'hFF,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'hFF,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'hFF,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'hFF,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[31:24], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[23:16], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[15:8],  1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b1, KIND_ERROR,   ERR_BAD_WAVE);
        add_row(TAG_RIFF[31:24], 1'b1, 1'b1, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[23:16], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[15:8],  1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_RIFF[7:0],   1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(8'h00,           1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[31:24], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[23:16], 1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[15:8],  1'b0, 1'b0, KIND_HEADER,  ERR_NONE);
        add_row(TAG_WAVE[7:0],   1'b0, 1'b1, KIND_HEADER,  ERR_NONE);
        add_row(8'h5A,           1'b0, 1'b1, KIND_IGNORED, ERR_NONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            offer_byte(directed_rows[k].value, directed_rows[k].start);
            r = parse_byte(directed_rows[k].value, directed_rows[k].start);
            if (directed_rows[k].typed) begin
                r.kind = directed_rows[k].kind;
                r.err  = directed_rows[k].err;
            end
            expected_results.push_back(r);
        end
        wait_drained();

        tx_idle_pct = 33;
        rx_idle_pct = 61;
        while (random_sent < RANDOM_ITEMS / 3)
            send_wav_file();
        tx_idle_pct = 61;
        rx_idle_pct = 33;
        while (random_sent < 2 * RANDOM_ITEMS / 3)
            send_wav_file();
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go <= 1'b1;
        while (random_sent < RANDOM_ITEMS)
            send_wav_file();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
